>>> sv/pqd_pkg.sv
// Shared types, constants and codes for the palette quantizer with dithering.
// No dependencies; every other file but the checker imports this package.
`default_nettype none
package pqd_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int PALETTE_DEPTH = 256;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int COLP_W = COL_W + 1;
  localparam int PAL_AW = $clog2(PALETTE_DEPTH);
  localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);

  typedef logic [7:0]        chan_t;
  typedef chan_t [2:0]       rgb_t;
  typedef logic signed [8:0] err_t;
  typedef err_t [2:0]        err3_t;

  localparam logic [1:0] REG_DITHER = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_COUNT  = 2'd3;

  typedef struct packed {
    logic        dither;
    logic [10:0] width;
    logic [15:0] height;
    logic [8:0]  count;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [PAL_AW-1:0] addr;
    rgb_t              data;
  } pal_wr_t;

  typedef struct packed {
    logic             start;
    rgb_t             pixel;
    logic [CNT_W-1:0] count;
  } search_req_t;

  typedef struct packed {
    logic              done;
    logic [PAL_AW-1:0] best;
    rgb_t              best_rgb;
  } search_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE, S_UL, S_UP, S_UR, S_LEFT, S_START, S_WAIT, S_WRITE
  } state_t;

endpackage
`default_nettype wire

>>> sv/palette_quantize_dither.sv
// Top level of the palette quantizer with Floyd-Steinberg dithering: register
// port, sequencer, palette search unit and error line buffer. Depends on pqd_pkg.
//
// Load items (command 0) write one palette entry. A pixel is held against the
// first palette_count entries, palette_count clamped to 1..256: the
// palette memory gives one entry per cycle to a three-stage distance and
// compare pipeline, around which come four error diffusion steps, the search
// start and the error write-back. One pixel is worked on at a time; a finished
// result waits in the output register while the next item is taken in. The
// palette and line buffer hold no reset values and need no clearing pass.
`default_nettype none
module palette_quantize_dither (
  input  wire         clk,
  input  wire         rst,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         command,
  input  wire  [7:0]  entry_index,
  input  wire  [7:0]  red,
  input  wire  [7:0]  green,
  input  wire  [7:0]  blue,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  color_index,
  output logic        row_end,
  output logic        frame_end
);
  import pqd_pkg::*;

  cfg_t        cfg;
  pal_wr_t     pal_wr;
  search_req_t req;
  search_rsp_t rsp;

  logic             line_we, line_re;
  logic [COL_W-1:0] line_waddr, line_raddr;
  err3_t            line_wdata, line_rdata;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dither <= 1'b0;
      cfg.width  <= 11'd320;
      cfg.height <= 16'd200;
      cfg.count  <= 9'd240;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DITHER: cfg.dither <= pwdata[0];
        REG_WIDTH:  cfg.width  <= pwdata[10:0];
        REG_HEIGHT: cfg.height <= pwdata[15:0];
        REG_COUNT:  cfg.count  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DITHER: prdata = {31'd0, cfg.dither};
      REG_WIDTH:  prdata = {21'd0, cfg.width};
      REG_HEIGHT: prdata = {16'd0, cfg.height};
      REG_COUNT:  prdata = {23'd0, cfg.count};
      default:    prdata = '0;
    endcase
  end

  pqd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .entry_index (entry_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .pal_wr      (pal_wr),
    .req         (req),
    .rsp         (rsp),
    .line_we     (line_we),
    .line_waddr  (line_waddr),
    .line_wdata  (line_wdata),
    .line_re     (line_re),
    .line_raddr  (line_raddr),
    .line_rdata  (line_rdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .color_index (color_index),
    .row_end     (row_end),
    .frame_end   (frame_end)
  );

  pqd_search u_search (
    .clk    (clk),
    .rst    (rst),
    .pal_wr (pal_wr),
    .req    (req),
    .rsp    (rsp)
  );

  pqd_line u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .re    (line_re),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

endmodule
`default_nettype wire

>>> sv/pqd_search.sv
// Palette memory and nearest-entry search, one entry read per cycle.
// Depends on pqd_pkg.
`default_nettype none
module pqd_search (
  input  wire                 clk,
  input  wire                 rst,
  input  pqd_pkg::pal_wr_t     pal_wr,
  input  pqd_pkg::search_req_t req,
  output pqd_pkg::search_rsp_t rsp
);
  import pqd_pkg::*;

  rgb_t mem [PALETTE_DEPTH];
  rgb_t rd_data;

  logic              running;
  logic [PAL_AW-1:0] cnt;
  logic [PAL_AW-1:0] last_cnt;
  rgb_t              pix;

  logic              rd_valid;
  logic              rd_last;
  logic [PAL_AW-1:0] rd_idx;

  logic              sq_valid;
  logic              sq_last;
  logic [PAL_AW-1:0] sq_idx;
  rgb_t              sq_rgb;
  logic [2:0][15:0]  sq;

  logic              done;
  logic [17:0]       best_d;
  logic [PAL_AW-1:0] best;
  rgb_t              best_rgb;

  logic [2:0][15:0]  sq_next;
  logic [17:0]       d;

  always_ff @(posedge clk) begin
    if (pal_wr.we) begin
      mem[pal_wr.addr] <= pal_wr.data;
    end
    if (running) begin
      rd_data <= mem[cnt];
    end
  end

  always_comb begin
    logic signed [8:0]  dt;
    logic signed [17:0] prod;
    for (int ch = 0; ch < 3; ch++) begin
      dt          = $signed({1'b0, pix[ch]}) - $signed({1'b0, rd_data[ch]});
      prod        = 18'(dt) * 18'(dt);
      sq_next[ch] = prod[15:0];
    end
    d = 18'(sq[0]) + 18'(sq[1]) + 18'(sq[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      rd_valid <= 1'b0;
      sq_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      rd_valid <= running;
      sq_valid <= rd_valid;
      done     <= sq_valid && sq_last;
      if (req.start) begin
        running <= 1'b1;
      end else if (running && cnt == last_cnt) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt      <= '0;
      pix      <= req.pixel;
      last_cnt <= PAL_AW'(req.count - 1'b1);
    end else if (running) begin
      cnt <= cnt + 1'b1;
    end
    rd_idx  <= cnt;
    rd_last <= (cnt == last_cnt);
    sq_idx  <= rd_idx;
    sq_last <= rd_last;
    sq_rgb  <= rd_data;
    sq      <= sq_next;
    if (sq_valid && (sq_idx == '0 || d < best_d)) begin
      best_d   <= d;
      best     <= sq_idx;
      best_rgb <= sq_rgb;
    end
  end

  assign rsp.done     = done;
  assign rsp.best     = best;
  assign rsp.best_rgb = best_rgb;

endmodule
`default_nettype wire

>>> sv/pqd_line.sv
// Line buffer of the previous row's per-channel quantization errors.
// Depends on pqd_pkg.
`default_nettype none
module pqd_line (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [pqd_pkg::COL_W-1:0] waddr,
  input  pqd_pkg::err3_t            wdata,
  input  wire                      re,
  input  wire  [pqd_pkg::COL_W-1:0] raddr,
  output pqd_pkg::err3_t            rdata
);
  import pqd_pkg::*;

  err3_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> sv/pqd_ctrl.sv
// Pixel sequencer: input transfer, error diffusion steps, search request,
// error write-back, raster counters and the output register.
// Depends on pqd_pkg.
`default_nettype none
module pqd_ctrl (
  input  wire                      clk,
  input  wire                      rst,
  input  pqd_pkg::cfg_t             cfg,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire                      command,
  input  wire  [7:0]               entry_index,
  input  wire  [7:0]               red,
  input  wire  [7:0]               green,
  input  wire  [7:0]               blue,
  output pqd_pkg::pal_wr_t          pal_wr,
  output pqd_pkg::search_req_t      req,
  input  pqd_pkg::search_rsp_t      rsp,
  output logic                     line_we,
  output logic [pqd_pkg::COL_W-1:0] line_waddr,
  output pqd_pkg::err3_t            line_wdata,
  output logic                     line_re,
  output logic [pqd_pkg::COL_W-1:0] line_raddr,
  input  pqd_pkg::err3_t            line_rdata,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic [7:0]               color_index,
  output logic                     row_end,
  output logic                     frame_end
);
  import pqd_pkg::*;

  function automatic chan_t add_share(input chan_t v, input err_t e, input logic [2:0] k);
    logic signed [12:0] p;
    logic signed [12:0] q;
    logic signed [12:0] s;
    p = 13'(e) * $signed({10'd0, k});
    q = p[12] ? ((p + 13'sd15) >>> 4) : (p >>> 4);
    s = $signed({5'd0, v}) + q;
    if (s < 0) begin
      return 8'd0;
    end else if (s > 13'sd255) begin
      return 8'd255;
    end
    return s[7:0];
  endfunction

  state_t           state, state_next;
  rgb_t             v, v_next;
  err3_t            upper_err;
  err3_t            left_err;
  err3_t            saved_ul;
  logic [COL_W-1:0] column;
  logic [15:0]      row;

  logic [COLP_W-1:0] w_eff;
  logic [15:0]       h_eff;
  logic [CNT_W-1:0]  n_eff;
  logic              last_col, last_row;
  logic              use_up, use_ul, use_ur, use_left;
  logic              accept, accept_pixel, load_out;
  err3_t             e;

  always_comb begin
    if (cfg.width == '0) begin
      w_eff = COLP_W'(1);
    end else if (32'(cfg.width) > MAX_WIDTH) begin
      w_eff = COLP_W'(MAX_WIDTH);
    end else begin
      w_eff = COLP_W'(cfg.width);
    end
    h_eff = (cfg.height == '0) ? 16'd1 : cfg.height;
    if (cfg.count == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(cfg.count) > PALETTE_DEPTH) begin
      n_eff = CNT_W'(PALETTE_DEPTH);
    end else begin
      n_eff = CNT_W'(cfg.count);
    end
  end

  assign last_col = (32'(column) + 1 >= 32'(w_eff));
  assign last_row = (17'(row) + 17'd1 >= 17'(h_eff));
  assign use_up   = cfg.dither && row != '0;
  assign use_ul   = use_up && column != '0;
  assign use_ur   = use_up && !last_col;
  assign use_left = cfg.dither && column != '0;

  assign accept       = (state == S_IDLE) && in_valid;
  assign accept_pixel = accept && command;
  assign load_out     = (state == S_WRITE) && !(out_valid && out_stall);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      e[ch] = $signed({1'b0, v[ch]}) - $signed({1'b0, rsp.best_rgb[ch]});
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept_pixel) state_next = S_UL;
      S_UL:    state_next = S_UP;
      S_UP:    state_next = S_UR;
      S_UR:    state_next = S_LEFT;
      S_LEFT:  state_next = S_START;
      S_START: state_next = S_WAIT;
      S_WAIT:  if (rsp.done) state_next = S_WRITE;
      S_WRITE: if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall     = (state != S_IDLE);
    pal_wr.we    = accept && !command && (32'(entry_index) < PALETTE_DEPTH);
    pal_wr.addr  = PAL_AW'(entry_index);
    pal_wr.data  = {blue, green, red};
    req.start    = (state == S_START);
    req.pixel    = v;
    req.count    = n_eff;
    line_re      = 1'b0;
    line_raddr   = column;
    line_we      = load_out;
    line_waddr   = column;
    line_wdata   = e;
    v_next       = v;
    case (state)
      S_IDLE: begin
        line_re = 1'b1;
        if (accept_pixel) v_next = {blue, green, red};
      end
      S_UL: begin
        line_re    = 1'b1;
        line_raddr = COL_W'(column + 1'b1);
        if (use_ul) begin
          for (int ch = 0; ch < 3; ch++) v_next[ch] = add_share(v[ch], saved_ul[ch], 3'd1);
        end
      end
      S_UP: begin
        if (use_up) begin
          for (int ch = 0; ch < 3; ch++) v_next[ch] = add_share(v[ch], upper_err[ch], 3'd5);
        end
      end
      S_UR: begin
        if (use_ur) begin
          for (int ch = 0; ch < 3; ch++) v_next[ch] = add_share(v[ch], line_rdata[ch], 3'd3);
        end
      end
      S_LEFT: begin
        if (use_left) begin
          for (int ch = 0; ch < 3; ch++) v_next[ch] = add_share(v[ch], left_err[ch], 3'd7);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      column    <= '0;
      row       <= '0;
      left_err  <= '0;
      saved_ul  <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (load_out) begin
        if (last_col) begin
          column   <= '0;
          row      <= last_row ? '0 : row + 1'b1;
          left_err <= '0;
          saved_ul <= '0;
        end else begin
          column   <= column + 1'b1;
          left_err <= e;
          saved_ul <= upper_err;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    v <= v_next;
    if (state == S_UL) begin
      upper_err <= line_rdata;
    end
    if (load_out) begin
      color_index <= 8'(rsp.best);
      row_end     <= last_col;
      frame_end   <= last_col && last_row;
    end
  end

endmodule
`default_nettype wire

>>> sv/pqd_checker.sv
// Port-level checks for palette_quantize_dither, attached by bind.
// No package dependencies.
`default_nettype none
module pqd_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_stall,
  input wire       command,
  input wire       out_valid,
  input wire       out_stall,
  input wire [7:0] color_index,
  input wire       row_end,
  input wire       frame_end
);

  // a waiting result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(color_index) && $stable(row_end)
                               && $stable(frame_end))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> row_end)
    else $error("frame end without row end");

  // a pixel keeps the block busy; a palette load does not
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command |=> in_stall)
    else $error("pixel transfer did not occupy the block");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !command |=> !in_stall)
    else $error("palette load stalled the input");

  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind palette_quantize_dither pqd_checker u_pqd_checker (.*);
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for palette_quantize_dither: palette loads and pixels on
// the input channel, color indices with row and frame flags on the output.
// Depends on pqd_pkg and the palette_quantize_dither RTL.
module testbench;
  import pqd_pkg::*;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;
  localparam int LOAD_SETTLE     = 16;
  localparam int FINAL_SETTLE    = 300;
  localparam int DRAIN_LIMIT     = 200000;
  localparam int LONG_HOLD       = 600;
  localparam int FULL_ROW_PIXELS = MAX_WIDTH + 20;
  localparam int RANDOM_PHASES   = 10;

  typedef enum int {FLOW_FREE, FLOW_SEND_GAPS, FLOW_STALLS, FLOW_BOTH} flow_t;

  typedef struct packed {
    logic [7:0] color_idx;
    logic       last_in_row;
    logic       last_in_frame;
  } pixel_result_t;

  class palette_scoreboard;
    rgb_t          pal_mem[PALETTE_DEPTH];
    err3_t         line_err[MAX_WIDTH];
    err3_t         left_err;
    err3_t         upleft_err;
    int unsigned   col;
    int unsigned   row;
    cfg_t          cfg;
    pixel_result_t indices_due[$];
    int            errors;
    int            checked;
    int            loads;

    function new();
      foreach (pal_mem[i]) pal_mem[i] = '0;
      foreach (line_err[i]) line_err[i] = '0;
      left_err   = '0;
      upleft_err = '0;
      col        = 0;
      row        = 0;
      cfg.dither = 1'b0;
      cfg.width  = 11'd320;
      cfg.height = 16'd200;
      cfg.count  = 9'd240;
      errors     = 0;
      checked    = 0;
      loads      = 0;
    endfunction

    function void set_reg(logic [1:0] reg_id, logic [31:0] value);
      case (reg_id)
        REG_DITHER: cfg.dither = value[0];
        REG_WIDTH:  cfg.width  = value[10:0];
        REG_HEIGHT: cfg.height = value[15:0];
        REG_COUNT:  cfg.count  = value[8:0];
        default: ;
      endcase
    endfunction

    function int add_error_share(int level, err_t e, int k);
      int s;
      s = level + (int'(e) * k) / 16;
      if (s < 0) s = 0;
      if (s > 255) s = 255;
      return s;
    endfunction

    function int unsigned nearest_entry(int level[3]);
      int unsigned n;
      int unsigned best;
      int best_d;
      int d;
      int t;
      n = cfg.count;
      if (n < 1) n = 1;
      if (n > PALETTE_DEPTH) n = PALETTE_DEPTH;
      best   = 0;
      best_d = 0;
      for (int unsigned i = 0; i < n; i++) begin
        d = 0;
        for (int ch = 0; ch < 3; ch++) begin
          t = level[ch] - int'(pal_mem[i][ch]);
          d += t * t;
        end
        if (i == 0 || d < best_d) begin
          best_d = d;
          best   = i;
        end
      end
      return best;
    endfunction

    function void note_item(logic cmd, logic [7:0] slot, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b);
      int unsigned w;
      int unsigned h;
      int unsigned x;
      int unsigned best;
      int level[3];
      rgb_t px;
      err_t e;
      logic last_col;
      logic last_row;
      pixel_result_t res;
      if (cmd == CMD_LOAD) begin
        pal_mem[slot] = {b, g, r};
        loads++;
        return;
      end
      w = cfg.width;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = cfg.height;
      if (h < 1) h = 1;
      x = col;
      last_col = (x + 1 >= w);
      last_row = (row + 1 >= h);
      px = {b, g, r};
      for (int ch = 0; ch < 3; ch++) begin
        level[ch] = int'(px[ch]);
        if (cfg.dither) begin
          if (row > 0) begin
            if (x > 0) level[ch] = add_error_share(level[ch], upleft_err[ch], 1);
            level[ch] = add_error_share(level[ch], line_err[x][ch], 5);
            if (!last_col) level[ch] = add_error_share(level[ch], line_err[x + 1][ch], 3);
          end
          if (x > 0) level[ch] = add_error_share(level[ch], left_err[ch], 7);
        end
      end
      best = nearest_entry(level);
      for (int ch = 0; ch < 3; ch++) begin
        e = 9'(level[ch] - int'(pal_mem[best][ch]));
        upleft_err[ch]  = line_err[x][ch];
        line_err[x][ch] = e;
        left_err[ch]    = e;
      end
      res.color_idx     = 8'(best);
      res.last_in_row   = last_col;
      res.last_in_frame = last_col && last_row;
      indices_due.push_back(res);
      if (last_col) begin
        col        = 0;
        row        = last_row ? 0 : row + 1;
        left_err   = '0;
        upleft_err = '0;
      end else begin
        col = x + 1;
      end
    endfunction

    function void check_pixel(logic [7:0] ci, logic re, logic fe);
      pixel_result_t want;
      if (indices_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected output transfer, color_index %0d row_end %0b frame_end %0b",
                 $time, ci, re, fe);
        return;
      end
      want = indices_due.pop_front();
      checked++;
      if (ci !== want.color_idx) begin
        errors++;
        $display("%0t: color_index expected %0d got %0d", $time, want.color_idx, ci);
      end
      if (re !== want.last_in_row) begin
        errors++;
        $display("%0t: row_end expected %0b got %0b", $time, want.last_in_row, re);
      end
      if (fe !== want.last_in_frame) begin
        errors++;
        $display("%0t: frame_end expected %0b got %0b", $time, want.last_in_frame, fe);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;
  logic        in_valid = 1'b0;
  wire         in_stall;
  logic        command = CMD_LOAD;
  logic [7:0]  entry_index = '0;
  logic [7:0]  red = '0;
  logic [7:0]  green = '0;
  logic [7:0]  blue = '0;
  wire         out_valid;
  logic        out_stall = 1'b0;
  wire  [7:0]  color_index;
  wire         row_end;
  wire         frame_end;

  palette_scoreboard sb;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int reg_writes = 0;

  palette_quantize_dither u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .entry_index(entry_index), .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .color_index(color_index), .row_end(row_end), .frame_end(frame_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_pixel(color_index, row_end, frame_end);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [7:0] rand_level();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic set_flow(input flow_t flow);
    case (flow)
      FLOW_FREE:      begin send_gap_pct = 0;  stall_pct = 0;  end
      FLOW_SEND_GAPS: begin send_gap_pct = 74; stall_pct = 0;  end
      FLOW_STALLS:    begin send_gap_pct = 0;  stall_pct = 74; end
      default:        begin send_gap_pct = 30; stall_pct = 30; end
    endcase
  endtask

  task automatic apb_write(input logic [1:0] reg_id, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_id, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(reg_id, value);
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic cmd, input logic [7:0] slot, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    entry_index <= slot;
    red         <= r;
    green       <= g;
    blue        <= b;
    do @(posedge clk); while (in_stall);
    sb.note_item(cmd, slot, r, g, b);
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    send_item(CMD_PIXEL, 8'($urandom_range(255)), r, g, b);
  endtask

  task automatic wait_idle(input int settle);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.indices_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.indices_due.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d pixel transfers never came out", $time, sb.indices_due.size());
      sb.indices_due.delete();
    end
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int n;
    int slot;
    rgb_t dup;
    logic [31:0] width_val;
    logic [31:0] height_val;
    logic [31:0] count_val;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    set_flow(FLOW_FREE);

    // small frame, ties on duplicate entries and on equal distances
    apb_write(REG_DITHER, 0);
    apb_write(REG_WIDTH, 3);
    apb_write(REG_HEIGHT, 2);
    apb_write(REG_COUNT, 6);
    send_item(CMD_LOAD, 8'd0, 8'd0, 8'd0, 8'd0);
    send_item(CMD_LOAD, 8'd1, 8'd255, 8'd255, 8'd255);
    send_item(CMD_LOAD, 8'd2, 8'd128, 8'd0, 8'd255);
    send_item(CMD_LOAD, 8'd3, 8'd128, 8'd0, 8'd255);
    send_item(CMD_LOAD, 8'd4, 8'd60, 8'd60, 8'd60);
    send_item(CMD_LOAD, 8'd5, 8'd80, 8'd60, 8'd60);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd0, 8'd255);
    send_pixel(8'd70, 8'd60, 8'd60);
    send_pixel(8'd1, 8'd2, 8'd3);
    send_pixel(8'd254, 8'd253, 8'd252);
    wait_idle(LOAD_SETTLE);

    apb_write(REG_DITHER, 1);
    send_pixel(8'd127, 8'd127, 8'd127);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd200, 8'd50, 8'd250);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd70, 8'd60, 8'd60);
    wait_idle(LOAD_SETTLE);

    // zero registers clamp to one
    apb_write(REG_WIDTH, 0);
    apb_write(REG_HEIGHT, 0);
    apb_write(REG_COUNT, 0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd9, 8'd9, 8'd9);
    wait_idle(LOAD_SETTLE);

    // width shrunk in the middle of a row
    apb_write(REG_WIDTH, 5);
    apb_write(REG_HEIGHT, 2);
    apb_write(REG_COUNT, 6);
    send_pixel(8'd30, 8'd200, 8'd90);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    wait_idle(LOAD_SETTLE);
    apb_write(REG_WIDTH, 2);
    send_pixel(8'd90, 8'd90, 8'd90);
    send_pixel(8'd250, 8'd10, 8'd10);
    send_pixel(8'd10, 8'd250, 8'd10);
    wait_idle(LOAD_SETTLE);

    // fill the whole palette, with some repeated colors
    set_flow(FLOW_SEND_GAPS);
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      if (i > 0 && $urandom_range(7) == 0) begin
        dup = sb.pal_mem[$urandom_range(i - 1)];
        send_item(CMD_LOAD, 8'(i), dup[0], dup[1], dup[2]);
      end else begin
        send_item(CMD_LOAD, 8'(i), rand_level(), rand_level(), rand_level());
      end
    end
    wait_idle(LOAD_SETTLE);

    // full width row and into the next, output held off at the start
    set_flow(FLOW_FREE);
    apb_write(REG_DITHER, 1);
    apb_write(REG_WIDTH, 2047);
    apb_write(REG_HEIGHT, 65535);
    apb_write(REG_COUNT, 16);
    hold_left = LONG_HOLD;
    for (int i = 0; i < FULL_ROW_PIXELS; i++) send_pixel(rand_level(), rand_level(), rand_level());
    wait_idle(LOAD_SETTLE);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_flow(flow_t'(phase % 4));
      case (phase)
        0: begin width_val = 0;    height_val = 1;     count_val = 256; end
        1: begin width_val = 1;    height_val = 0;     count_val = 1;   end
        2: begin width_val = 1024; height_val = 65535; count_val = 0;   end
        3: begin width_val = 2047; height_val = 2;     count_val = 511; end
        default: begin
          width_val  = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(24, 1);
          height_val = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(6, 1);
          count_val  = ($urandom_range(5) == 0) ? $urandom_range(511) : $urandom_range(32, 1);
        end
      endcase
      apb_write(REG_DITHER, $urandom_range(1));
      apb_write(REG_WIDTH, width_val);
      apb_write(REG_HEIGHT, height_val);
      apb_write(REG_COUNT, count_val);
      n = $urandom_range(50, 30);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0) begin
          slot = $urandom_range(255);
          send_item(CMD_LOAD, 8'(slot), rand_level(), rand_level(), rand_level());
        end else begin
          send_pixel(rand_level(), rand_level(), rand_level());
        end
      end
      wait_idle(LOAD_SETTLE);
    end

    wait_idle(FINAL_SETTLE);
    $display("Checked %0d pixel transfers and %0d palette loads over %0d register writes,",
             sb.checked, sb.loads, reg_writes);
    $display("plain and dithered, clamped registers, width changes and a long output hold.");
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
